>>> rtl/dvc_pkg.sv
// dvc_pkg: shared types and constants of the distinct value counter.
// Used by every module of the block; depends on nothing.
package dvc_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int VALUE_W         = 32;
  localparam int COUNT_W         = 9;
  localparam int OUT_TDATA_W     = 16;

  // Token that walks down the cell chain, one cell per cycle while the chain advances.
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               hit;    // value already present or stored on the way
    logic [VALUE_W-1:0] value;
  } token_t;

endpackage

>>> rtl/dvc_cell.sv
// dvc_cell: one table entry of the chain plus the token register behind it.
// Depends on dvc_pkg.
module dvc_cell import dvc_pkg::*; #(
  parameter int CNT_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  token_t           tok_i,
  input  logic [CNT_W-1:0] cnt_i,
  output token_t           tok_o,
  output logic [CNT_W-1:0] cnt_o
);

  logic               ent_vld_r;
  logic [VALUE_W-1:0] ent_val_r;
  token_t             tok_r;
  logic [CNT_W-1:0]   cnt_r;

  logic match;
  logic ins;

  assign match = ent_vld_r && (ent_val_r == tok_i.value);
  assign ins   = tok_i.vld && !tok_i.hit && !match && !ent_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r.vld   <= tok_i.vld;
      tok_r.last  <= tok_i.last;
      tok_r.hit   <= tok_i.hit | match | ins;
      tok_r.value <= tok_i.value;
      cnt_r       <= cnt_i + CNT_W'(ent_vld_r | ins);
      if (ins) begin
        ent_val_r <= tok_i.value;
      end
      // the closing item of a set wipes each entry as it passes
      if (tok_i.vld && tok_i.last) begin
        ent_vld_r <= 1'b0;
      end else if (ins) begin
        ent_vld_r <= 1'b1;
      end
    end
  end

  assign tok_o = tok_r;
  assign cnt_o = cnt_r;

endmodule

>>> rtl/dvc_tail.sv
// dvc_tail: chain exit; tracks table overflow and holds the result register.
// Depends on dvc_pkg.
module dvc_tail import dvc_pkg::*; #(
  parameter int CNT_W = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  token_t                 tok_i,
  input  logic [CNT_W-1:0]       cnt_i,
  output logic                   adv,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   out_vld_r;
  logic [COUNT_W-1:0]     count_r;
  logic                   ovf_out_r;
  logic                   ovf_r;
  logic                   miss;

  assign miss = !tok_i.hit;
  assign adv  = !(tok_i.vld && tok_i.last && out_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (adv && tok_i.vld) begin
        if (tok_i.last) begin
          out_vld_r <= 1'b1;
          ovf_r     <= 1'b0;
        end else if (miss) begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_i.vld && tok_i.last) begin
      count_r   <= COUNT_W'(cnt_i);
      ovf_out_r <= ovf_r | miss;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-COUNT_W-1){1'b0}}, ovf_out_r, count_r};

endmodule

>>> rtl/distinct_value_counter.sv
// distinct_value_counter: top level, a chain of TABLE_DEPTH cells and an exit stage.
// Depends on dvc_pkg, dvc_cell and dvc_tail.
//
// Counts the distinct 32-bit values of a set that ends with the item carrying
// in_tlast. One item is taken every cycle while the chain does not stall; each
// item walks the chain of TABLE_DEPTH cells, one cell per cycle, and is stored in
// the first free cell unless an earlier cell already holds it. A set's result is
// registered by the exit stage once its last item has passed every cell; the next
// set may follow right behind, since the last item empties each cell as it passes.
// The chain stalls only while a result waits at out_tready and the next set's
// last item has reached the end of the chain. If a set holds more distinct
// values than TABLE_DEPTH, the count saturates at TABLE_DEPTH (kept to 9 bits)
// and the overflow bit is set.
module distinct_value_counter import dvc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [VALUE_W-1:0]     in_tdata,   // [31:0] value
  input  logic                   in_tlast,   // last
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [8:0] distinct_count, [9] overflow
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  token_t           tok [TABLE_DEPTH+1];
  logic [CNT_W-1:0] cnt [TABLE_DEPTH+1];
  logic             adv;

  assign tok[0] = '{vld: in_tvalid, last: in_tlast, hit: 1'b0, value: in_tdata};
  assign cnt[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    dvc_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok[i]),
      .cnt_i (cnt[i]),
      .tok_o (tok[i+1]),
      .cnt_o (cnt[i+1])
    );
  end

  dvc_tail #(
    .CNT_W (CNT_W)
  ) u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_i      (tok[TABLE_DEPTH]),
    .cnt_i      (cnt[TABLE_DEPTH]),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign in_tready = adv;

endmodule

>>> rtl/dvc_checker.sv
// dvc_checker: port-level checks of distinct_value_counter, bound to the top.
// Depends on dvc_pkg and distinct_value_counter.
module dvc_checker import dvc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [COUNT_W-1:0] SAT_COUNT = COUNT_W'(TABLE_DEPTH);
  localparam logic               WRAPS     = (TABLE_DEPTH >= (1 << COUNT_W));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[COUNT_W] |-> out_tdata[COUNT_W-1:0] == SAT_COUNT)
    else $error("overflow without saturated count");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> WRAPS || (out_tdata[COUNT_W-1:0] != '0))
    else $error("empty set reported");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind distinct_value_counter dvc_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_dvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
